FILE: rtl/core/wges_pkg.sv
package wges_pkg;

	localparam int unsigned VERTEX_COUNT_DEF = 8;
	localparam int unsigned WEIGHT_BITS_DEF  = 16;

	typedef enum logic [2:0] {
		STATUS_NEIGHBOR = 3'd0,
		STATUS_MISSING  = 3'd1,
		STATUS_ISOLATED = 3'd2,
		STATUS_REMOVED  = 3'd3,
		STATUS_INSERTED = 3'd4,
		STATUS_UPDATED  = 3'd5
	} status_t;

	typedef enum logic {
		KIND_QUERY = 1'b0,
		KIND_SET   = 1'b1
	} kind_t;

endpackage

FILE: rtl/core/wges_if.sv
interface wges_req_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [7:0]         first_vertex;
	logic [7:0]         second_vertex;
	logic signed [15:0] new_weight;

	modport source (output valid, kind, first_vertex, second_vertex, new_weight, input ready);
	modport sink (input valid, kind, first_vertex, second_vertex, new_weight, output ready);
endinterface

interface wges_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [7:0]         neighbor_id;
	logic signed [15:0] edge_weight;
	logic               last;

	modport source (output valid, status, neighbor_id, edge_weight, last, input ready);
	modport sink (input valid, status, neighbor_id, edge_weight, last, output ready);
endinterface

FILE: rtl/core/wges_ram.sv
module wges_ram #(
	parameter int unsigned WIDTH = 17,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/weighted_graph_edge_store.sv
// Edge store for an undirected weighted graph over vertex ids 1..VERTEX_COUNT.
// Items arrive on the request channel and results leave on the result channel,
// both valid/ready; an item moves at a clock edge with valid and ready high.
// A set item (kind 1) writes the edge weight symmetrically and gives one result:
// it passes through the read, check and write-back states before its result is registered.
// A query item (kind 0) reads one row of the adjacency memory, one vertex per
// cycle unless the result register stalls, over its single read port, and gives
// one result per neighbor in ascending id order, the last one flagged, or one
// result with status 2 if none. Unknown ids give a single result with status 1.
// One item is worked on at a time; request ready is high only while idle.
// After reset all VERTEX_COUNT squared entries of the memory are cleared one
// entry per cycle, while request ready stays low.
// The result sits in an output register; while the receiver stalls, the block
// holds its scan and resumes once the register is taken.
module weighted_graph_edge_store import wges_pkg::*; #(
	parameter int unsigned VERTEX_COUNT = VERTEX_COUNT_DEF,
	parameter int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	wges_req_if.sink   request,
	wges_res_if.source result
);

	localparam int unsigned CELLS = VERTEX_COUNT * VERTEX_COUNT;
	localparam int unsigned AW    = $clog2(CELLS);
	localparam int unsigned IW    = $clog2(VERTEX_COUNT);
	localparam int unsigned CW    = $clog2(VERTEX_COUNT + 1);
	localparam int unsigned MW    = WEIGHT_BITS + 1;
	localparam logic [AW-1:0] V_A     = AW'(VERTEX_COUNT);
	localparam logic [AW-1:0] LAST_A  = AW'(CELLS - 1);
	localparam logic [CW-1:0] V_C     = CW'(VERTEX_COUNT);
	localparam logic [7:0]    V_ID    = 8'(VERTEX_COUNT);
	localparam logic signed [32:0] W_HI = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
	localparam logic signed [32:0] W_LO = -W_HI - 33'sd1;

	typedef enum logic [6:0] {
		ST_CLEAR   = 7'b0000001,
		ST_IDLE    = 7'b0000010,
		ST_SCAN    = 7'b0000100,
		ST_SET_RD  = 7'b0001000,
		ST_SET_CHK = 7'b0010000,
		ST_SET_WB  = 7'b0100000,
		ST_BAD     = 7'b1000000
	} state_t;

	function automatic logic [WEIGHT_BITS-1:0] fit_weight(input logic signed [15:0] w);
		logic signed [32:0] x;
		logic signed [32:0] y;
		x = 33'(w);
		if (x > W_HI) begin
			y = W_HI;
		end else if (x < W_LO) begin
			y = W_LO;
		end else begin
			y = x;
		end
		return y[WEIGHT_BITS-1:0];
	endfunction

	function automatic logic [15:0] out_weight(input logic [WEIGHT_BITS-1:0] s);
		logic [32:0] x;
		x = {{(33 - WEIGHT_BITS){s[WEIGHT_BITS-1]}}, s};
		return x[15:0];
	endfunction

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic [IW-1:0]       a_q;
	logic [IW-1:0]       b_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic                remove_q;
	status_t             set_status_q;
	logic [CW-1:0]       col_q;
	logic                s1_valid_q;
	logic [IW-1:0]       col_s1;
	logic                pend_valid_q;
	logic [7:0]          pend_id_q;
	logic [WEIGHT_BITS-1:0] pend_w_q;

	logic                out_valid_q;
	status_t             out_status_q;
	logic [7:0]          out_id_q;
	logic [15:0]         out_w_q;
	logic                out_last_q;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [MW-1:0]       mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic [MW-1:0]       mem_rdata;

	logic                slot_free;
	logic                accept;
	logic                a_ok;
	logic                b_ok;
	logic [IW-1:0]       a_idx;
	logic [IW-1:0]       b_idx;
	logic [AW-1:0]       addr_ab;
	logic [AW-1:0]       addr_ba;
	logic [AW-1:0]       addr_scan;
	logic                hit;
	logic                stall;
	logic                issue;
	logic                done;

	logic                emit;
	status_t             emit_status;
	logic [7:0]          emit_id;
	logic [15:0]         emit_w;
	logic                emit_last;
	logic                take_pend;

	wges_ram #(
		.WIDTH(MW),
		.DEPTH(CELLS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign slot_free = !out_valid_q || result.ready;
	assign request.ready = (state_q == ST_IDLE);
	assign accept = request.valid && request.ready;

	assign a_ok  = (request.first_vertex != 8'd0) && (request.first_vertex <= V_ID);
	assign b_ok  = (request.second_vertex != 8'd0) && (request.second_vertex <= V_ID);
	assign a_idx = IW'(request.first_vertex - 8'd1);
	assign b_idx = IW'(request.second_vertex - 8'd1);

	assign addr_ab   = AW'(a_q) * V_A + AW'(b_q);
	assign addr_ba   = AW'(b_q) * V_A + AW'(a_q);
	assign addr_scan = AW'(a_q) * V_A + AW'(col_q[IW-1:0]);

	assign hit   = s1_valid_q && mem_rdata[WEIGHT_BITS];
	assign stall = hit && pend_valid_q && !slot_free;
	assign issue = (state_q == ST_SCAN) && !stall && (col_q != V_C);
	assign done  = !s1_valid_q && (col_q == V_C);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = addr_scan;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_SCAN: begin
				mem_re = issue;
			end
			ST_SET_RD: begin
				mem_re    = 1'b1;
				mem_raddr = addr_ab;
			end
			ST_SET_CHK: begin
				mem_we    = 1'b1;
				mem_waddr = addr_ab;
				mem_wdata = remove_q ? '0 : {1'b1, w_q};
			end
			ST_SET_WB: begin
				mem_we    = 1'b1;
				mem_waddr = addr_ba;
				mem_wdata = remove_q ? '0 : {1'b1, w_q};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		emit        = 1'b0;
		emit_status = STATUS_NEIGHBOR;
		emit_id     = 8'd0;
		emit_w      = 16'd0;
		emit_last   = 1'b1;
		take_pend   = 1'b0;
		case (state_q)
			ST_SCAN: begin
				if (hit && pend_valid_q && slot_free) begin
					emit      = 1'b1;
					emit_id   = pend_id_q;
					emit_w    = out_weight(pend_w_q);
					emit_last = 1'b0;
				end else if (done && slot_free) begin
					emit = 1'b1;
					if (pend_valid_q) begin
						emit_id = pend_id_q;
						emit_w  = out_weight(pend_w_q);
					end else begin
						emit_status = STATUS_ISOLATED;
					end
				end
				take_pend = hit && !stall;
			end
			ST_SET_WB: begin
				emit        = slot_free;
				emit_status = set_status_q;
			end
			ST_BAD: begin
				emit        = slot_free;
				emit_status = STATUS_MISSING;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			col_q        <= '0;
			s1_valid_q   <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_A) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (request.kind == KIND_QUERY) begin
							state_q <= a_ok ? ST_SCAN : ST_BAD;
						end else begin
							state_q <= (a_ok && b_ok) ? ST_SET_RD : ST_BAD;
						end
						col_q        <= '0;
						s1_valid_q   <= 1'b0;
						pend_valid_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (!stall) begin
						s1_valid_q <= issue;
						if (issue) begin
							col_q <= col_q + CW'(1);
						end
					end
					if (take_pend) begin
						pend_valid_q <= 1'b1;
					end
					if (done && slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SET_RD: begin
					state_q <= ST_SET_CHK;
				end
				ST_SET_CHK: begin
					state_q <= ST_SET_WB;
				end
				ST_SET_WB: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_BAD: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q      <= a_idx;
			b_q      <= b_idx;
			w_q      <= fit_weight(request.new_weight);
			remove_q <= (request.new_weight == 16'sd0);
		end
		if (issue) begin
			col_s1 <= col_q[IW-1:0];
		end
		if (take_pend) begin
			pend_id_q <= 8'(col_s1) + 8'd1;
			pend_w_q  <= mem_rdata[WEIGHT_BITS-1:0];
		end
		if (state_q == ST_SET_CHK) begin
			if (remove_q) begin
				set_status_q <= STATUS_REMOVED;
			end else if (mem_rdata[WEIGHT_BITS]) begin
				set_status_q <= STATUS_UPDATED;
			end else begin
				set_status_q <= STATUS_INSERTED;
			end
		end
		if (emit) begin
			out_status_q <= emit_status;
			out_id_q     <= emit_id;
			out_w_q      <= emit_w;
			out_last_q   <= emit_last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.status      = out_status_q;
	assign result.neighbor_id = out_id_q;
	assign result.edge_weight = out_w_q;
	assign result.last        = out_last_q;

endmodule
